// ----- hw/rtl/ks01_pkg.sv -----
// ks01_pkg: shared types and defaults for the 0/1 knapsack block
// transaction payload structs, table control struct, default sizes
// no dependencies
`default_nettype none

package ks01_pkg;

  localparam int MAX_ITEMS_DEF  = 32;
  localparam int MAX_WEIGHT_DEF = 1023;
  localparam int VALUE_BITS_DEF = 16;

  localparam int WEIGHT_W = 10;
  localparam int VALUE_W  = 16;
  localparam int TOTAL_W  = 21;
  localparam int NUMBER_W = 6;

  localparam logic RES_SUMMARY = 1'b0;
  localparam logic RES_ITEM    = 1'b1;

  typedef struct packed {
    logic [WEIGHT_W-1:0] item_weight;
    logic [VALUE_W-1:0]  item_value;
    logic                last_item;
  } item_t;

  typedef struct packed {
    logic                result_kind;
    logic [TOTAL_W-1:0]  total_value;
    logic [WEIGHT_W-1:0] total_weight;
    logic [NUMBER_W-1:0] item_number;
    logic                overflow;
    logic                last_result;
  } result_t;

  typedef struct packed {
    logic best_we;
    logic scr_we;
    logic chc_set;
    logic chc_clr;
  } tbl_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ks01_tables.sv -----
// ks01_tables: the weight-indexed memories of the knapsack block
// best value table (two read ports), pass scratch table, choice bit rows
// depends on ks01_pkg
`default_nettype none

module ks01_tables #(
  parameter int DEPTH = ks01_pkg::MAX_WEIGHT_DEF + 1,
  parameter int AW    = 10,
  parameter int SW    = 22,
  parameter int TW    = 6,
  parameter int NI    = ks01_pkg::MAX_ITEMS_DEF,
  parameter int IXW   = 5
) (
  input  wire logic               clk,
  input  wire ks01_pkg::tbl_ctl_t ctl,
  input  wire logic [AW-1:0]      wa,
  input  wire logic [SW:0]        best_wd,
  input  wire logic [TW+SW-1:0]   scr_wd,
  input  wire logic [IXW-1:0]     chc_bit,
  input  wire logic [AW-1:0]      ra_a,
  input  wire logic [AW-1:0]      ra_b,
  input  wire logic [AW-1:0]      rc,
  output      logic [SW:0]        rd_a,
  output      logic [SW:0]        rd_b,
  output      logic [TW+SW-1:0]   rd_s,
  output      logic [NI-1:0]      rd_c
);
  import ks01_pkg::*;

  // entry: {reachable, value}
  logic [SW:0]      best_mem [DEPTH];
  // entry: {pass tag, value}
  logic [TW+SW-1:0] scr_mem  [DEPTH];
  logic [NI-1:0]    chc_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.best_we) begin
      best_mem[wa] <= best_wd;
    end
    rd_a <= best_mem[ra_a];
    rd_b <= best_mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (ctl.scr_we) begin
      scr_mem[wa] <= scr_wd;
    end
    rd_s <= scr_mem[ra_a];
  end

  always_ff @(posedge clk) begin
    if (ctl.chc_clr) begin
      chc_mem[wa] <= '0;
    end else if (ctl.chc_set) begin
      chc_mem[wa][chc_bit] <= 1'b1;
    end
    rd_c <= chc_mem[rc];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/knapsack_01_dp_traceback.sv -----
// knapsack_01_dp_traceback: 0/1 knapsack table pass per item, traceback on the last item
// one item pass: busy from the accept, one table entry per cycle through the update sweep
// and again through the merge sweep on the single-ported write path
// last item adds a traceback that checks each stored item from the last down, then a clear
// pass over all MAX_WEIGHT+1 entries; reset also starts that clear pass, busy stays high meanwhile
// results are one-cycle strobes, the receiver cannot stall them
`default_nettype none

module knapsack_01_dp_traceback #(
  parameter int MAX_ITEMS  = ks01_pkg::MAX_ITEMS_DEF,
  parameter int MAX_WEIGHT = ks01_pkg::MAX_WEIGHT_DEF,
  parameter int VALUE_BITS = ks01_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire ks01_pkg::item_t             item,
  input  wire logic                        cfg_we,
  input  wire logic [ks01_pkg::WEIGHT_W-1:0] cfg_wdata,
  output      logic                        result_valid,
  output      ks01_pkg::result_t           result
);
  import ks01_pkg::*;

  localparam int DEPTH = MAX_WEIGHT + 1;
  localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(MAX_ITEMS + 1);
  localparam int IXW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SW    = VALUE_BITS + IW;
  localparam int WW    = ((AW > WEIGHT_W) ? AW : WEIGHT_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_UPD, S_MRG, S_TB_RD, S_TB_CHK
  } state_t;

  state_t              state;
  logic [WEIGHT_W-1:0] capacity;
  logic [AW-1:0]       cap_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [VALUE_BITS-1:0] v_r;
  logic                last_r;
  logic [IW-1:0]       cnt;
  logic                dropped;
  logic [AW-1:0]       best_weight;
  logic [SW-1:0]       bw_value;
  logic [AW-1:0]       j;
  logic                iss;
  logic                s1_valid;
  logic                s1_ok;
  logic [AW-1:0]       s1_j;
  logic [AW-1:0]       s1_t;
  logic [AW-1:0]       pos;
  logic [IW-1:0]       tb_i;
  logic                pend_kind;
  logic [IW-1:0]       pend_num;
  logic [WEIGHT_W-1:0] wts [MAX_ITEMS];

  tbl_ctl_t            ctl;
  logic [AW-1:0]       wa;
  logic [SW:0]         best_wd;
  logic [IW+SW-1:0]    scr_wd;
  logic [SW:0]         rd_a;
  logic [SW:0]         rd_b;
  logic [IW+SW-1:0]    rd_s;
  logic [MAX_ITEMS-1:0] rd_c;
  logic [AW-1:0]       ra_b;
  logic [SW-1:0]       cand;
  logic                upd_hit;
  logic                mrg_hit;
  logic [AW-1:0]       cap_eff;
  logic [IXW-1:0]      tb_idx;
  result_t             pend_res;

  assign busy = (state != S_IDLE);

  assign cap_eff = (WW'(capacity) > WW'(MAX_WEIGHT)) ? AW'(MAX_WEIGHT) : AW'(capacity);
  assign ra_b    = AW'(WW'(j) + WW'(w_r));
  assign cand    = SW'(rd_a[SW-1:0]) + SW'(v_r);
  assign tb_idx  = IXW'(tb_i - IW'(1));

  // candidate wins over the old table entry at the target weight
  assign upd_hit = (state == S_UPD) && s1_valid && s1_ok && rd_a[SW] &&
                   (!rd_b[SW] || (cand > rd_b[SW-1:0]));
  assign mrg_hit = (state == S_MRG) && s1_valid && (rd_s[IW+SW-1:SW] == cnt);

  always_comb begin
    ctl.best_we = (state == S_CLEAR) || mrg_hit;
    ctl.scr_we  = (state == S_CLEAR) || upd_hit;
    ctl.chc_clr = (state == S_CLEAR);
    ctl.chc_set = upd_hit;
    case (state)
      S_CLEAR: wa = j;
      S_UPD:   wa = s1_t;
      default: wa = s1_j;
    endcase
    if (state == S_CLEAR) begin
      best_wd = {(j == '0), SW'(0)};
      scr_wd  = {{IW{1'b1}}, SW'(0)};
    end else begin
      best_wd = {1'b1, rd_s[SW-1:0]};
      scr_wd  = {cnt, cand};
    end
    pend_res.result_kind  = pend_kind;
    pend_res.total_value  = (pend_kind == RES_SUMMARY) ? TOTAL_W'(bw_value) : '0;
    pend_res.total_weight = (pend_kind == RES_SUMMARY) ? WEIGHT_W'(best_weight) : '0;
    pend_res.item_number  = (pend_kind == RES_SUMMARY) ? '0 : NUMBER_W'(pend_num);
    pend_res.overflow     = dropped;
    // the pending result goes out from S_TB_RD only when the traceback is done
    pend_res.last_result  = (state == S_TB_RD);
  end

  ks01_tables #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .SW    (SW),
    .TW    (IW),
    .NI    (MAX_ITEMS),
    .IXW   (IXW)
  ) u_tables (
    .clk     (clk),
    .ctl     (ctl),
    .wa      (wa),
    .best_wd (best_wd),
    .scr_wd  (scr_wd),
    .chc_bit (cnt[IXW-1:0]),
    .ra_a    (j),
    .ra_b    (ra_b),
    .rc      (pos),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .rd_s    (rd_s),
    .rd_c    (rd_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      capacity     <= WEIGHT_W'(1023);
      j            <= '0;
      iss          <= 1'b0;
      s1_valid     <= 1'b0;
      cnt          <= '0;
      dropped      <= 1'b0;
      best_weight  <= '0;
      bw_value     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          if (j == AW'(MAX_WEIGHT)) begin
            state       <= S_IDLE;
            cnt         <= '0;
            dropped     <= 1'b0;
            best_weight <= '0;
            bw_value    <= '0;
          end else begin
            j <= j + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            pos       <= best_weight;
            pend_kind <= RES_SUMMARY;
            pend_num  <= '0;
            if (cnt < IW'(MAX_ITEMS)) begin
              cap_r           <= cap_eff;
              j               <= cap_eff;
              w_r             <= item.item_weight;
              v_r             <= VALUE_BITS'(item.item_value);
              last_r          <= item.last_item;
              wts[cnt[IXW-1:0]] <= item.item_weight;
              iss             <= 1'b1;
              s1_valid        <= 1'b0;
              state           <= S_UPD;
            end else begin
              dropped <= 1'b1;
              if (item.last_item) begin
                tb_i  <= cnt;
                state <= S_TB_RD;
              end
            end
          end
        end
        S_UPD, S_MRG: begin
          s1_valid <= iss;
          if (iss) begin
            s1_j  <= j;
            s1_t  <= ra_b;
            s1_ok <= (WW'(w_r) <= (WW'(cap_r) - WW'(j)));
            if (state == S_UPD) begin
              if (j == '0) iss <= 1'b0;
              else         j   <= j - AW'(1);
            end else begin
              if (j == cap_r) iss <= 1'b0;
              else            j   <= j + AW'(1);
            end
          end
          // track best weight in ascending order, strict compare
          if (mrg_hit) begin
            if (s1_j == best_weight) begin
              bw_value <= rd_s[SW-1:0];
            end else if (bw_value < rd_s[SW-1:0]) begin
              bw_value    <= rd_s[SW-1:0];
              best_weight <= s1_j;
            end
          end
          if (!iss && !s1_valid) begin
            if (state == S_UPD) begin
              state <= S_MRG;
              j     <= '0;
              iss   <= 1'b1;
            end else begin
              cnt  <= cnt + IW'(1);
              tb_i <= cnt + IW'(1);
              pos  <= best_weight;
              state <= last_r ? S_TB_RD : S_IDLE;
            end
          end
        end
        S_TB_RD: begin
          if (tb_i == '0) begin
            result_valid <= 1'b1;
            result       <= pend_res;
            j            <= '0;
            state        <= S_CLEAR;
          end else begin
            state <= S_TB_CHK;
          end
        end
        S_TB_CHK: begin
          if (rd_c[tb_idx]) begin
            result_valid <= 1'b1;
            result       <= pend_res;
            pend_kind    <= RES_ITEM;
            pend_num     <= tb_i;
            pos          <= AW'(WW'(pos) - WW'(wts[tb_idx]));
          end
          tb_i  <= tb_i - IW'(1);
          state <= S_TB_RD;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

`default_nettype wire
